FILE: design/msbs_pkg.sv
// shared constants, types and codes for the multi-signature byte scanner
package msbs_pkg;

  // default sizes
  localparam int NUM_SIGS_DEF       = 8;
  localparam int MAX_SIG_LEN_DEF    = 32;
  localparam int MAX_SCAN_BYTES_DEF = 16384;

  // slots reachable through the slot field
  localparam int ADDR_SLOTS = 8;

  // payload field widths
  localparam int MODE_W   = 3;
  localparam int SLOT_W   = 3;
  localparam int INDEX_W  = 5;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 6;
  localparam int OFFSET_W = 14;

  // item modes
  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR_TABLE = 3'd0,
    MODE_SET_LENGTH  = 3'd1,
    MODE_LOAD_BYTE   = 3'd2,
    MODE_NEW_FILE    = 3'd3,
    MODE_SCAN_BYTE   = 3'd4
  } mode_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic              step;       // advance the partial match bits with feed
    logic              fake;       // fed byte lies before the file start
    logic              shift;      // move the window one cell along
    logic              clear_win;  // zero the window
    logic              clear_m;    // zero the partial match bits
    logic              wr_en;      // write one signature byte
    logic [SLOT_W-1:0] wr_slot;
    logic [INDEX_W-1:0] wr_index;
    logic [BYTE_W-1:0] wr_data;
    logic [BYTE_W-1:0] feed;       // byte matched this cycle
  } cell_ctrl_t;

endpackage

FILE: design/msbs_cell.sv
// one cell of the matching chain: a window byte, one signature column, partial match bits
module msbs_cell #(
  parameter int NS       = msbs_pkg::ADDR_SLOTS,
  parameter int CELL_IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  msbs_pkg::cell_ctrl_t        ctrl,
  input  logic [msbs_pkg::BYTE_W-1:0] byte_in,
  input  logic [NS-1:0]               m_in,
  output logic [msbs_pkg::BYTE_W-1:0] byte_out,
  output logic [NS-1:0]               m_out,
  output logic [NS-1:0]               m_upd
);
  import msbs_pkg::*;

  logic [BYTE_W-1:0] win;
  logic [BYTE_W-1:0] sig [NS];
  logic [NS-1:0]     m;

  // prefix of length CELL_IDX+1 matched ending at the fed byte
  always_comb begin
    m_upd = m;
    if (ctrl.step) begin
      for (int s = 0; s < NS; s++) begin
        m_upd[s] = !ctrl.fake && m_in[s] && (ctrl.feed == sig[s]);
      end
    end else if (ctrl.clear_m) begin
      m_upd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
      m   <= '0;
    end else begin
      m <= m_upd;
      if (ctrl.shift) begin
        win <= byte_in;
      end else if (ctrl.clear_win) begin
        win <= '0;
      end
    end
  end

  // signature column, undefined until loaded
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && (32'(ctrl.wr_index) == CELL_IDX)) begin
      for (int s = 0; s < NS; s++) begin
        if (32'(ctrl.wr_slot) == s) begin
          sig[s] <= ctrl.wr_data;
        end
      end
    end
  end

  assign byte_out = win;
  assign m_out    = m;

endmodule

FILE: design/msbs_report.sv
// holds the hits of one scanned byte and sends them out highest slot first
module msbs_report #(
  parameter int NS    = msbs_pkg::ADDR_SLOTS,
  parameter int CNT_W = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic [NS-1:0]                       hits_in,
  input  logic [CNT_W-1:0]                    count_in,
  input  logic [NS-1:0][msbs_pkg::LEN_W-1:0]  lens,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic                                busy,
  output logic [msbs_pkg::OFFSET_W-1:0]       match_offset,
  output logic [msbs_pkg::SLOT_W-1:0]         match_slot,
  output logic [msbs_pkg::LEN_W-1:0]          match_length,
  output logic                                last
);
  import msbs_pkg::*;

  localparam int DW = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;

  logic [NS-1:0]    hits;
  logic [CNT_W-1:0] cnt;
  logic [NS-1:0]    sel_mask;
  logic [LEN_W-1:0] sel_len;
  logic [DW-1:0]    diff;

  // highest pending slot
  always_comb begin
    match_slot = '0;
    sel_mask   = '0;
    sel_len    = '0;
    for (int s = 0; s < NS; s++) begin
      if (hits[s]) begin
        match_slot = SLOT_W'(s);
        sel_mask   = NS'(1) << s;
        sel_len    = lens[s];
      end
    end
  end

  assign diff         = DW'(cnt) - DW'(sel_len);
  assign match_offset = diff[OFFSET_W-1:0];
  assign match_length = sel_len;
  assign last         = (hits & ~sel_mask) == '0;
  assign out_valid    = |hits;
  assign busy         = |hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      hits <= '0;
    end else if (load) begin
      hits <= hits_in;
    end else if (out_valid && !out_stall) begin
      hits <= hits & ~sel_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cnt <= count_in;
    end
  end

endmodule

FILE: design/multi_signature_byte_scanner_top.sv
// top level of the multi-signature byte scanner
// Scans a file byte stream for up to eight signatures loaded beforehand. Each signature
// position is a cell in a chain; every cell keeps one window byte, the signature bytes of
// that position for all slots, and one partial-match bit per slot (the signature prefix
// ending there has matched the most recent bytes). A scanned byte moves all bits one cell
// along. For a byte with matches the report unit sends one transfer per match, highest
// slot first, with last set on the final one; intake waits during that burst. Loading a
// signature byte while the byte count is nonzero rebuilds the partial-match bits by
// rotating the window once around the chain, during which no item is taken; loads made
// right after reset or a new-file item need no rebuild. Table clear, slot length and
// new-file items never stall intake. Bytes past MAX_SCAN_BYTES in one file are dropped.
module multi_signature_byte_scanner_top #(
  parameter int NUM_SIGS       = msbs_pkg::NUM_SIGS_DEF,
  parameter int MAX_SIG_LEN    = msbs_pkg::MAX_SIG_LEN_DEF,
  parameter int MAX_SCAN_BYTES = msbs_pkg::MAX_SCAN_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [msbs_pkg::MODE_W-1:0]   mode,
  input  logic [msbs_pkg::SLOT_W-1:0]   slot,
  input  logic [msbs_pkg::INDEX_W-1:0]  byte_index,
  input  logic [msbs_pkg::BYTE_W-1:0]   data_byte,
  input  logic [msbs_pkg::LEN_W-1:0]    sig_length,
  // report channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [msbs_pkg::OFFSET_W-1:0] match_offset,
  output logic [msbs_pkg::SLOT_W-1:0]   match_slot,
  output logic [msbs_pkg::LEN_W-1:0]    match_length,
  output logic                          last
);
  import msbs_pkg::*;

  // only slots the slot field can reach take part
  localparam int NS    = (NUM_SIGS < ADDR_SLOTS) ? NUM_SIGS : ADDR_SLOTS;
  localparam int CNT_W = $clog2(MAX_SCAN_BYTES + 1);
  localparam int AGE_W = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;

  cell_ctrl_t ctrl;

  logic [BYTE_W-1:0] win   [MAX_SIG_LEN];
  logic [NS-1:0]     m_cur [MAX_SIG_LEN];
  logic [NS-1:0]     m_upd [MAX_SIG_LEN];

  logic [NS-1:0][LEN_W-1:0] lens;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;

  // window rebuild after a signature byte load
  logic             replay;
  logic [AGE_W-1:0] age;

  logic          accept;
  logic          busy;
  logic          scan_ok;
  logic          wr_ok;
  logic          report_load;
  logic [NS-1:0] hits;
  logic [LEN_W-1:0] len_sat;

  assign accept  = in_valid && !in_stall;
  assign in_stall = replay || busy;

  assign scan_ok = 32'(count) < MAX_SCAN_BYTES;
  assign wr_ok   = (32'(slot) < NS) && (32'(byte_index) < MAX_SIG_LEN);
  assign len_sat = (32'(sig_length) > MAX_SIG_LEN) ? LEN_W'(MAX_SIG_LEN) : sig_length;
  assign count_next = count + CNT_W'(1);

  // chain control
  always_comb begin
    ctrl          = '0;
    ctrl.wr_slot  = slot;
    ctrl.wr_index = byte_index;
    ctrl.wr_data  = data_byte;
    ctrl.feed     = data_byte;
    report_load   = 1'b0;
    if (replay) begin
      // oldest byte first; bytes older than the file start only clear the bits
      ctrl.step  = 1'b1;
      ctrl.shift = 1'b1;
      ctrl.fake  = !(32'(age) < 32'(count));
      ctrl.feed  = win[MAX_SIG_LEN-1];
    end else if (accept) begin
      case (mode)
        MODE_SCAN_BYTE: begin
          if (scan_ok) begin
            ctrl.step   = 1'b1;
            ctrl.shift  = 1'b1;
            report_load = |hits;
          end
        end
        MODE_NEW_FILE: begin
          ctrl.clear_win = 1'b1;
          ctrl.clear_m   = 1'b1;
        end
        MODE_LOAD_BYTE: begin
          if (wr_ok) begin
            ctrl.wr_en   = 1'b1;
            ctrl.clear_m = count != '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // the chain
  for (genvar j = 0; j < MAX_SIG_LEN; j++) begin : g_cell
    logic [BYTE_W-1:0] byte_in;
    logic [NS-1:0]     m_in;
    if (j == 0) begin : g_head
      assign byte_in = ctrl.feed;
      assign m_in    = '1;
    end else begin : g_link
      assign byte_in = win[j-1];
      assign m_in    = m_cur[j-1];
    end
    msbs_cell #(
      .NS       (NS),
      .CELL_IDX (j)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .byte_in  (byte_in),
      .m_in     (m_in),
      .byte_out (win[j]),
      .m_out    (m_cur[j]),
      .m_upd    (m_upd[j])
    );
  end

  // a slot hits when the cell at its length holds a full prefix match
  always_comb begin
    hits = '0;
    for (int s = 0; s < NS; s++) begin
      for (int j = 0; j < MAX_SIG_LEN; j++) begin
        if (m_upd[j][s] && (32'(lens[s]) == j + 1)) begin
          hits[s] = 1'b1;
        end
      end
    end
  end

  // slot lengths, byte count and rebuild sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      lens   <= '0;
      count  <= '0;
      replay <= 1'b0;
      age    <= '0;
    end else if (replay) begin
      age <= age - AGE_W'(1);
      if (age == '0) begin
        replay <= 1'b0;
      end
    end else if (accept) begin
      case (mode)
        MODE_CLEAR_TABLE: begin
          lens <= '0;
        end
        MODE_SET_LENGTH: begin
          for (int s = 0; s < NS; s++) begin
            if (32'(slot) == s) begin
              lens[s] <= len_sat;
            end
          end
        end
        MODE_LOAD_BYTE: begin
          if (wr_ok && (count != '0)) begin
            replay <= 1'b1;
            age    <= AGE_W'(MAX_SIG_LEN - 1);
          end
        end
        MODE_NEW_FILE: begin
          count <= '0;
        end
        MODE_SCAN_BYTE: begin
          if (scan_ok) begin
            count <= count_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  msbs_report #(
    .NS    (NS),
    .CNT_W (CNT_W)
  ) u_report (
    .clk          (clk),
    .rst          (rst),
    .load         (report_load),
    .hits_in      (hits),
    .count_in     (count_next),
    .lens         (lens),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .busy         (busy),
    .match_offset (match_offset),
    .match_slot   (match_slot),
    .match_length (match_length),
    .last         (last)
  );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the multi-signature byte scanner
module testbench;
  import msbs_pkg::*;

  // sizes of the block as built with its defaults
  localparam int NSIG         = NUM_SIGS_DEF;
  localparam int SIG_LEN      = MAX_SIG_LEN_DEF;
  localparam int SCAN_LIMIT   = MAX_SCAN_BYTES_DEF;
  localparam int LEN_MAX      = 2**LEN_W - 1;
  localparam int RANDOM_ITEMS = 225;
  localparam int QUIET_ITEMS  = 100;      // opening random stretch with no idling
  localparam int IDLE_PCT     = 22;
  localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
  localparam int PRESS_ITEMS  = 40;
  localparam int DRAIN_CYCLES = 2 * SIG_LEN + 16;  // covers one window rebuild
  localparam int TIMEOUT_NS   = 10_000_000;

  // mode codes the package leaves unnamed; the block must ignore them
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = '1;

  // one input transfer
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [SLOT_W-1:0]  slot;
    logic [INDEX_W-1:0] idx;
    logic [BYTE_W-1:0]  data;
    logic [LEN_W-1:0]   len;
  } byte_cmd_t;

  // one match report
  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [SLOT_W-1:0]   slot;
    logic [LEN_W-1:0]    len;
    logic                last;
  } match_t;

  // how a directed row is checked: by the scanner model, no report at all,
  // or one report typed into the table
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} check_t;

  typedef struct packed {
    byte_cmd_t cmd;
    check_t    check;
    match_t    want;
  } dir_row_t;

  // dut ports
  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [MODE_W-1:0]   mode       = '0;
  logic [SLOT_W-1:0]   slot       = '0;
  logic [INDEX_W-1:0]  byte_index = '0;
  logic [BYTE_W-1:0]   data_byte  = '0;
  logic [LEN_W-1:0]    sig_length = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [OFFSET_W-1:0] match_offset;
  logic [SLOT_W-1:0]   match_slot;
  logic [LEN_W-1:0]    match_length;
  logic                last;

  // scanner model state
  logic [7:0] model_window [SIG_LEN];       // entry 0 is the newest file byte
  logic [7:0] model_sigs   [NSIG][SIG_LEN];
  bit         model_known  [NSIG][SIG_LEN]; // signature bytes written so far
  int         model_len    [NSIG];
  int         model_pos;                    // file bytes taken in this file

  match_t     step_hits[$];        // reports caused by the latest transfer
  match_t     pending_matches[$];  // reports still owed by the block
  int         errors      = 0;
  int         items_taken = 0;
  int         gap_pct     = IDLE_PCT;
  int         stall_pct   = IDLE_PCT;
  bit         pressure_go = 1'b0;
  logic       hold_on     = 1'b0;
  logic [7:0] alphabet [4];
  dir_row_t   dir_rows [22];

  multi_signature_byte_scanner_top dut (.*);

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // reset held at start-up, released once, never again
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // receiver: random stalls, overridden by the long hold-off
  always @(posedge clk)
    out_stall <= hold_on || ($urandom_range(99) < stall_pct);

  // long hold-off, counted here while the sender keeps offering bytes
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // run limit
  initial begin
    #TIMEOUT_NS;
    $display("Regression FAIL");
    $finish;
  end

  function automatic byte_cmd_t item_of(logic [MODE_W-1:0] m, int s, int i, int d, int l);
    return {m, SLOT_W'(s), INDEX_W'(i), BYTE_W'(d), LEN_W'(l)};
  endfunction

  // a file byte with noise on the fields the block ignores
  function automatic byte_cmd_t file_byte(int d);
    return item_of(MODE_SCAN_BYTE, $urandom_range(NSIG - 1), $urandom_range(SIG_LEN - 1),
                   d, $urandom_range(LEN_MAX));
  endfunction

  function automatic match_t sole_hit(int off, int s, int l);
    return {OFFSET_W'(off), SLOT_W'(s), LEN_W'(l), 1'b1};
  endfunction

  function automatic string show_match(match_t m);
    return $sformatf("offset=%0d slot=%0d length=%0d last=%0b", m.offset, m.slot, m.len, m.last);
  endfunction

  // mostly bytes from a small alphabet so that short signatures hit often
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(3) != 0) return alphabet[$urandom_range(3)];
    return 8'($urandom_range(255));
  endfunction

  // longest run of written signature bytes from the start of a slot
  function automatic int known_prefix(int s);
    int n;
    n = 0;
    while (n < SIG_LEN && model_known[s][n]) n++;
    return n;
  endfunction

  // true when slot s of length l ends with the newest file byte
  function automatic bit window_holds(int s, int l);
    for (int j = 0; j < l; j++)
      if (model_sigs[s][j] != model_window[l - 1 - j]) return 1'b0;
    return 1'b1;
  endfunction

  // advance the scanner model by one transfer, leaving its reports in step_hits
  function automatic void compute_matches(byte_cmd_t c);
    match_t m;
    step_hits.delete();
    case (c.mode)
      MODE_CLEAR_TABLE: for (int s = 0; s < NSIG; s++) model_len[s] = 0;
      MODE_SET_LENGTH: begin
        if (c.slot < NSIG) model_len[c.slot] = (c.len > SIG_LEN) ? SIG_LEN : int'(c.len);
      end
      MODE_LOAD_BYTE: begin
        if (c.slot < NSIG && c.idx < SIG_LEN) begin
          model_sigs[c.slot][c.idx]  = c.data;
          model_known[c.slot][c.idx] = 1'b1;
        end
      end
      MODE_NEW_FILE: begin
        model_pos = 0;
        for (int j = 0; j < SIG_LEN; j++) model_window[j] = '0;
      end
      MODE_SCAN_BYTE: begin
        // bytes past the scan limit leave everything as it is
        if (model_pos < SCAN_LIMIT) begin
          for (int j = SIG_LEN - 1; j > 0; j--) model_window[j] = model_window[j - 1];
          model_window[0] = c.data;
          model_pos++;
          // highest slot reports first; a signature longer than the file so far misses
          for (int s = NSIG - 1; s >= 0; s--) begin
            if (model_len[s] != 0 && model_len[s] <= model_pos && window_holds(s, model_len[s]))
            begin
              m = {OFFSET_W'(model_pos - model_len[s]), SLOT_W'(s), LEN_W'(model_len[s]), 1'b0};
              step_hits.push_back(m);
            end
          end
          if (step_hits.size() != 0) begin
            m = step_hits.pop_back();
            m.last = 1'b1;
            step_hits.push_back(m);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // offer one transfer, wait for it to be taken, then log what it owes
  task automatic send_cmd(byte_cmd_t c, check_t check = CHK_MODEL, match_t want = '0);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < gap_pct);
    end
    in_valid   <= 1'b1;
    mode       <= c.mode;
    slot       <= c.slot;
    byte_index <= c.idx;
    data_byte  <= c.data;
    sig_length <= c.len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    compute_matches(c);
    if (check == CHK_MODEL) foreach (step_hits[i]) pending_matches.push_back(step_hits[i]);
    else if (check == CHK_ONE) pending_matches.push_back(want);
    if (c.mode <= MODE_SCAN_BYTE) items_taken++;
  endtask

  // every accepted report is held against the oldest one owed
  always @(posedge clk) begin : report_check
    match_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {match_offset, match_slot, match_length, last};
      if (pending_matches.size() == 0) begin
        errors++;
        $display("%0t: report with none expected, expected nothing, got %s", $time,
                 show_match(got));
      end else begin
        want = pending_matches.pop_front();
        if (got.offset !== want.offset || got.slot !== want.slot || got.len !== want.len ||
            got.last !== want.last) begin
          errors++;
          $display("%0t: report mismatch, expected %s, got %s", $time, show_match(want),
                   show_match(got));
        end
      end
    end
  end

  initial begin
    int base, pick, s, n, roll;
    logic [7:0] press_byte;
    logic [7:0] long_sig [SIG_LEN];

    // model after reset
    for (int j = 0; j < SIG_LEN; j++) model_window[j] = '0;
    for (int k = 0; k < NSIG; k++) begin
      model_len[k] = 0;
      for (int j = 0; j < SIG_LEN; j++) begin
        model_sigs[k][j]  = '0;
        model_known[k][j] = 1'b0;
      end
    end
    model_pos = 0;

    // directed rows: empty table, short prefix, first hits, rebuild on load,
    // two hits on one byte, ignored mode, table clear, disabled slot, new file
    dir_rows = '{
      '{item_of(MODE_SCAN_BYTE,   0, 0,  8'h00, 0), CHK_NONE,  '0},
      '{item_of(MODE_LOAD_BYTE,   0, 0,  8'h00, 0), CHK_MODEL, '0},
      '{item_of(MODE_LOAD_BYTE,   0, 1,  8'h00, 0), CHK_MODEL, '0},
      '{item_of(MODE_SET_LENGTH,  0, 0,  8'h00, 2), CHK_MODEL, '0},
      '{item_of(MODE_NEW_FILE,    0, 0,  8'h00, 0), CHK_MODEL, '0},
      '{item_of(MODE_SCAN_BYTE,   0, 0,  8'h00, 0), CHK_NONE,  '0},
      '{item_of(MODE_SCAN_BYTE,   0, 0,  8'h00, 0), CHK_ONE,   sole_hit(0, 0, 2)},
      '{item_of(MODE_LOAD_BYTE,   5, 0,  8'hFF, 0), CHK_MODEL, '0},
      '{item_of(MODE_SET_LENGTH,  5, 0,  8'h00, 1), CHK_MODEL, '0},
      '{item_of(MODE_SCAN_BYTE,   0, 0,  8'hFF, 0), CHK_ONE,   sole_hit(2, 5, 1)},
      '{item_of(MODE_LOAD_BYTE,   0, 1,  8'hFF, 0), CHK_MODEL, '0},
      '{item_of(MODE_SCAN_BYTE,   0, 0,  8'h00, 0), CHK_MODEL, '0},
      '{item_of(MODE_SCAN_BYTE,   0, 0,  8'hFF, 0), CHK_MODEL, '0},
      '{item_of(MODE_SPARE_HI,    7, 31, 8'hFF, 63), CHK_NONE, '0},
      '{item_of(MODE_CLEAR_TABLE, 0, 0,  8'h00, 0), CHK_MODEL, '0},
      '{item_of(MODE_SCAN_BYTE,   0, 0,  8'hFF, 0), CHK_NONE,  '0},
      '{item_of(MODE_SET_LENGTH,  5, 0,  8'h00, 1), CHK_MODEL, '0},
      '{item_of(MODE_SCAN_BYTE,   0, 0,  8'hFF, 0), CHK_ONE,   sole_hit(6, 5, 1)},
      '{item_of(MODE_SET_LENGTH,  5, 0,  8'h00, 0), CHK_MODEL, '0},
      '{item_of(MODE_SCAN_BYTE,   0, 0,  8'hFF, 0), CHK_NONE,  '0},
      '{item_of(MODE_NEW_FILE,    0, 0,  8'h00, 0), CHK_MODEL, '0},
      '{item_of(MODE_SCAN_BYTE,   0, 0,  8'hFF, 0), CHK_NONE,  '0}
    };

    wait (!rst);
    @(posedge clk);
    foreach (dir_rows[r]) send_cmd(dir_rows[r].cmd, dir_rows[r].check, dir_rows[r].want);

    // full-length signature in the top slot, length field above the maximum saturates
    for (int j = 0; j < SIG_LEN; j++) begin
      long_sig[j] = 8'($urandom_range(255));
      send_cmd(item_of(MODE_LOAD_BYTE, NSIG - 1, j, long_sig[j], $urandom_range(LEN_MAX)));
    end
    send_cmd(item_of(MODE_SET_LENGTH, NSIG - 1, 0, 0, LEN_MAX));
    send_cmd(item_of(MODE_NEW_FILE, 0, 0, 0, 0));
    for (int j = 0; j < SIG_LEN; j++) send_cmd(file_byte(long_sig[j]));
    send_cmd(file_byte($urandom_range(255)));

    // back pressure: every slot hits on one byte, receiver holds off while bytes keep coming
    press_byte = 8'($urandom_range(255));
    for (int k = 0; k < NSIG; k++) begin
      send_cmd(item_of(MODE_LOAD_BYTE, k, 0, press_byte, 0));
      send_cmd(item_of(MODE_SET_LENGTH, k, 0, 0, 1));
    end
    gap_pct = 0;
    pressure_go = 1'b1;
    repeat (PRESS_ITEMS) send_cmd(file_byte(press_byte));

    // random part: mostly signatures programmed and then found in the file stream
    foreach (alphabet[k]) alphabet[k] = 8'($urandom_range(255));
    base = items_taken;
    while (items_taken - base < RANDOM_ITEMS) begin
      gap_pct = (items_taken - base < QUIET_ITEMS) ? 0 : IDLE_PCT;
      stall_pct <= (items_taken - base < QUIET_ITEMS) ? 0 : IDLE_PCT;
      pick = $urandom_range(99);
      if (pick < 15) begin
        // program a slot from byte 0 up, then enable it at that length
        s = $urandom_range(NSIG - 1);
        roll = $urandom_range(9);
        n = (roll < 7) ? $urandom_range(1, 4) : (roll < 9) ? $urandom_range(5, 12) : SIG_LEN;
        for (int j = 0; j < n; j++)
          send_cmd(item_of(MODE_LOAD_BYTE, s, j, pick_byte(), $urandom_range(LEN_MAX)));
        send_cmd(item_of(MODE_SET_LENGTH, s, $urandom_range(SIG_LEN - 1), $urandom_range(255),
                         (n == SIG_LEN) ? $urandom_range(SIG_LEN, LEN_MAX) : n));
      end else if (pick < 72) begin
        // a stretch of file bytes, some of them copies of an enabled signature
        repeat ($urandom_range(1, 12)) begin
          s = $urandom_range(NSIG - 1);
          if ($urandom_range(3) == 0 && model_len[s] != 0) begin
            for (int j = 0; j < model_len[s]; j++) send_cmd(file_byte(model_sigs[s][j]));
          end else begin
            send_cmd(file_byte(pick_byte()));
          end
        end
      end else if (pick < 82) begin
        // new length, never past the bytes written in that slot
        s = $urandom_range(NSIG - 1);
        n = known_prefix(s);
        send_cmd(item_of(MODE_SET_LENGTH, s, $urandom_range(SIG_LEN - 1), $urandom_range(255),
                         (n == SIG_LEN) ? $urandom_range(LEN_MAX) : $urandom_range(n)));
      end else if (pick < 89) begin
        send_cmd(item_of(MODE_LOAD_BYTE, $urandom_range(NSIG - 1), $urandom_range(SIG_LEN - 1),
                         $urandom_range(255), $urandom_range(LEN_MAX)));
      end else if (pick < 94) begin
        send_cmd(item_of(MODE_NEW_FILE, $urandom_range(NSIG - 1), $urandom_range(SIG_LEN - 1),
                         $urandom_range(255), $urandom_range(LEN_MAX)));
      end else if (pick < 97) begin
        send_cmd(item_of(MODE_CLEAR_TABLE, $urandom_range(NSIG - 1),
                         $urandom_range(SIG_LEN - 1), $urandom_range(255),
                         $urandom_range(LEN_MAX)));
      end else begin
        send_cmd(item_of(MODE_W'(MODE_SCAN_BYTE) + MODE_W'($urandom_range(1, 3)),
                         $urandom_range(NSIG - 1), $urandom_range(SIG_LEN - 1),
                         $urandom_range(255), $urandom_range(LEN_MAX)));
      end
    end

    // drain: wait for every owed report, then allow for a trailing rebuild
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_matches.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/msbs_pkg.sv
design/msbs_cell.sv
design/msbs_report.sv
design/multi_signature_byte_scanner_top.sv
sim/testbench.sv
